/* design/rgbhsl_pkg.sv */
`default_nettype none

package rgbhsl_pkg;

    localparam int ChanW    = 8;
    localparam int HueW     = 12;
    localparam int SumW     = ChanW + 1;
    // Hue dividend is 2*num + d with num below 3600*255, so 21 bits.
    localparam int RemW     = 21;
    localparam int DenW     = ChanW + 1;
    localparam int QuoW     = HueW;
    localparam int DivSteps = QuoW;
    localparam int StepIdxW = $clog2(QuoW);
    localparam int AccW     = RemW + 2;
    // First stage, dividend setup stage, one stage per quotient bit, output stage.
    localparam int PipeLat  = DivSteps + 3;

    localparam logic [HueW-1:0]  HueWrap = HueW'(3600);
    localparam logic [ChanW-1:0] ChanMax = '1;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        sector_t                  sector;
        logic                     neg;
        logic [ChanW-1:0]         spread;
        logic [SumW-1:0]          sum;
        logic signed [ChanW:0]    diff;
    } stage1_t;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [DenW-1:0] den;
        logic [QuoW-1:0] quo;
    } div_t;

    typedef struct packed {
        logic             gray;
        logic [ChanW-1:0] lum;
        div_t             hue;
        div_t             sat;
    } stage_t;

    typedef struct packed {
        logic [HueW-1:0]  hue;
        logic [ChanW-1:0] sat;
        logic [ChanW-1:0] lum;
    } result_t;

    // One restoring division step that decides quotient bit bit_pos.
    function automatic div_t div_step(div_t cur, logic [StepIdxW-1:0] bit_pos);
        logic [RemW-1:0] trial;
        logic [RemW:0]   delta;
        div_t            res;
        trial = RemW'(cur.den) << bit_pos;
        delta = {1'b0, cur.rem} - {1'b0, trial};
        res   = cur;
        if (!delta[RemW])
        begin
            res.rem          = delta[RemW-1:0];
            res.quo[bit_pos] = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/rgbhsl_rgb_if.sv */
`default_nettype none

interface rgbhsl_rgb_if;
    logic                           valid;
    logic                           ready;
    logic [rgbhsl_pkg::ChanW-1:0]   red_in;
    logic [rgbhsl_pkg::ChanW-1:0]   green_in;
    logic [rgbhsl_pkg::ChanW-1:0]   blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

/* design/rgbhsl_hsl_if.sv */
`default_nettype none

interface rgbhsl_hsl_if;
    logic                           valid;
    logic                           ready;
    logic [rgbhsl_pkg::HueW-1:0]    hue_tenths;
    logic [rgbhsl_pkg::ChanW-1:0]   sat_out;
    logic [rgbhsl_pkg::ChanW-1:0]   lum_out;

    modport source (output valid, output hue_tenths, output sat_out, output lum_out,
                    input ready);
    modport sink   (input valid, input hue_tenths, input sat_out, input lum_out,
                    output ready);
endinterface

`default_nettype wire

/* design/rgb_to_hsl_converter.sv */
// RGB to HSL pixel converter.
//
// Channel rgb (sink) takes one pixel item per cycle while hsl is not
// stalled: red_in, green_in and blue_in, each 0..255. Channel hsl (source)
// gives one item per pixel, in order: hue_tenths (0..3599 tenths of a
// degree), sat_out and lum_out (0..255 for 0.0..1.0), all rounded to nearest.
//
// The pipeline takes one pixel per cycle when hsl is not stalled: one
// stage finds max, min and the hue sector, one builds the dividends,
// twelve stages each settle one quotient bit of the hue and saturation
// divisions, and the last stage wraps the hue and registers the result.
//
// When the receiver holds hsl.ready low with a result waiting, the whole
// pipeline freezes and rgb.ready drops in the same cycle; empty slots keep
// moving, so the block keeps taking items until a result reaches the end.
// Reset clears only the valid bits; no pixel in flight survives it.
`default_nettype none

module rgb_to_hsl_converter (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rgbhsl_rgb_if.sink   rgb,
    rgbhsl_hsl_if.source hsl
);
    import rgbhsl_pkg::*;

    logic [PipeLat-1:0] vld_reg;
    logic [PipeLat-1:0] vld_next;
    logic               advance;

    stage1_t s1_reg;
    stage1_t s1_next;
    stage_t  pipe_reg  [DivSteps+1];
    stage_t  pipe_next [DivSteps+1];
    result_t out_reg;
    result_t out_next;

    // The pipeline moves as a whole unless a finished item is held at the end.
    assign advance   = !vld_reg[PipeLat-1] || hsl.ready;
    assign rgb.ready = advance;
    assign vld_next  = {vld_reg[PipeLat-2:0], rgb.valid};

    // Stage 1: max, min, spread and the hue sector.
    always_comb
    begin
        logic [ChanW-1:0] hi;
        logic [ChanW-1:0] lo;
        hi = rgb.red_in;
        lo = rgb.red_in;
        if (rgb.green_in > hi)
            hi = rgb.green_in;
        if (rgb.blue_in > hi)
            hi = rgb.blue_in;
        if (rgb.green_in < lo)
            lo = rgb.green_in;
        if (rgb.blue_in < lo)
            lo = rgb.blue_in;
        s1_next.spread = hi - lo;
        s1_next.sum    = SumW'(hi) + SumW'(lo);
        priority if (hi == rgb.red_in)
        begin
            s1_next.sector = SECT_RED;
            s1_next.diff   = $signed({1'b0, rgb.green_in}) - $signed({1'b0, rgb.blue_in});
        end
        else if (hi == rgb.green_in)
        begin
            s1_next.sector = SECT_GREEN;
            s1_next.diff   = $signed({1'b0, rgb.blue_in}) - $signed({1'b0, rgb.red_in});
        end
        else
        begin
            s1_next.sector = SECT_BLUE;
            s1_next.diff   = $signed({1'b0, rgb.red_in}) - $signed({1'b0, rgb.green_in});
        end
        s1_next.neg = s1_next.diff[ChanW];
    end

    // Stage 2: dividends and divisors for both rounded divisions.
    // round(num / d) is floor((2*num + d) / (2*d)); hue uses num in tenths.
    always_comb
    begin
        logic signed [AccW-1:0] d_ext;
        logic signed [AccW-1:0] diff_ext;
        logic signed [AccW-1:0] base;
        logic signed [AccW-1:0] acc;
        logic [SumW-1:0]        den;
        logic [RemW-1:0]        sat_num;
        d_ext    = $signed(AccW'(s1_reg.spread));
        diff_ext = AccW'(s1_reg.diff);
        unique case (s1_reg.sector)
            SECT_RED:   base = s1_reg.neg ? d_ext * AccW'(7200) : '0;
            SECT_GREEN: base = d_ext * AccW'(2400);
            SECT_BLUE:  base = d_ext * AccW'(4800);
            default:    base = '0;
        endcase
        acc = base + diff_ext * AccW'(1200) + d_ext;

        den = (s1_reg.sum <= SumW'(ChanMax)) ? s1_reg.sum
                                             : SumW'(2 * ChanMax) - s1_reg.sum;
        if (den == '0)
            den = SumW'(1);
        sat_num = RemW'(s1_reg.spread) * RemW'(2 * ChanMax) + RemW'(den);

        pipe_next[0].gray    = (s1_reg.spread == '0);
        pipe_next[0].lum     = ChanW'((s1_reg.sum + SumW'(1)) >> 1);
        pipe_next[0].hue.rem = acc[RemW-1:0];
        pipe_next[0].hue.den = {s1_reg.spread, 1'b0};
        pipe_next[0].hue.quo = '0;
        pipe_next[0].sat.rem = sat_num;
        pipe_next[0].sat.den = {den[ChanW-1:0], 1'b0};
        pipe_next[0].sat.quo = '0;
    end

    // Division stages, most significant quotient bit first.
    for (genvar k = 0; k < DivSteps; k++)
    begin : g_div
        always_comb
        begin
            pipe_next[k+1]     = pipe_reg[k];
            pipe_next[k+1].hue = div_step(pipe_reg[k].hue, StepIdxW'(DivSteps - 1 - k));
            pipe_next[k+1].sat = div_step(pipe_reg[k].sat, StepIdxW'(DivSteps - 1 - k));
        end
    end

    // Output stage: gray pixels force zero hue and saturation.
    always_comb
    begin
        logic [QuoW-1:0] hq;
        logic [QuoW-1:0] sq;
        hq = pipe_reg[DivSteps].hue.quo;
        sq = pipe_reg[DivSteps].sat.quo;
        out_next.lum = pipe_reg[DivSteps].lum;
        if (pipe_reg[DivSteps].gray)
        begin
            out_next.hue = '0;
            out_next.sat = '0;
        end
        else
        begin
            out_next.hue = (hq >= HueWrap) ? hq - HueWrap : hq;
            out_next.sat = (sq > QuoW'(ChanMax)) ? ChanMax : sq[ChanW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= s1_next;
            out_reg <= out_next;
            for (int i = 0; i <= DivSteps; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    assign hsl.valid      = vld_reg[PipeLat-1];
    assign hsl.hue_tenths = out_reg.hue;
    assign hsl.sat_out    = out_reg.sat;
    assign hsl.lum_out    = out_reg.lum;

    // An empty output stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !hsl.valid |-> rgb.ready)
        else $error("input refused while output stage is empty");

    // Hue stays wrapped below a full turn.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl.valid |-> (hsl.hue_tenths < HueWrap))
        else $error("hue out of range");

    // Zero saturation only happens for gray pixels, whose hue is zero.
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl.valid && (hsl.sat_out == '0)) |-> (hsl.hue_tenths == '0))
        else $error("zero saturation with nonzero hue");

    // A stalled result moves nothing forward in the pipeline.
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl.valid && !hsl.ready) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
